FILE: rtl/shkh_pkg.sv
// shared types and constants for the string key hash table
// no dependencies
package shkh_pkg;

    localparam int BUCKET_W      = 6;
    localparam int BUCKETS       = 1 << BUCKET_W;
    localparam int SLOT_IDX_W    = 4;
    localparam int SLOTS_PER_BKT = 1 << SLOT_IDX_W;
    localparam int TABLE_SLOTS   = BUCKETS * SLOTS_PER_BKT;
    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_W         = 8 * MAX_KEY_BYTES;
    localparam int LEN_W         = 4;
    localparam int CNT_W         = SLOT_IDX_W + 1;
    localparam int HASH_W        = 17;
    localparam int VALUE_W       = 32;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_FOUND   = 2'd1,
        ST_TABLE_FULL  = 2'd2,
        ST_KEY_TOO_LONG = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CNT,
        BS_PROBE,
        BS_MISS,
        BS_DONE
    } back_state_t;

    typedef struct packed {
        logic                cmd;
        logic                too_long;
        logic [BUCKET_W-1:0] bucket;
        logic [KEY_W-1:0]    key;
        logic [LEN_W-1:0]    len;
        logic [VALUE_W-1:0]  value;
    } job_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

endpackage

FILE: rtl/shkh_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module shkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/shkh_front.sv
// front end: folds key bytes into hash and key buffer, emits one job per key
// depends on shkh_pkg
module shkh_front import shkh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_cmd,
    input  logic [7:0]   s_key_byte,
    input  logic         s_key_last,
    input  logic [31:0]  s_value,
    output logic         job_valid,
    input  logic         job_ready,
    output job_t         job
);

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              ovf_reg, ovf_next;

    logic              byte_nz, take, accept;
    logic [8:0]        bp1;
    logic [17:0]       sq;
    logic [HASH_W-1:0] term, hash_c, final_hash;
    logic [KEY_W-1:0]  key_c;
    logic [LEN_W-1:0]  pos_c;
    logic              ovf_c;

    assign s_ready   = job_ready;
    assign accept    = s_valid && s_ready;
    assign job_valid = accept && s_key_last;

    always_comb begin
        byte_nz = s_key_byte != 8'd0;
        take    = byte_nz && (pos_reg < LEN_W'(MAX_KEY_BYTES));
        ovf_c   = ovf_reg | (byte_nz && !take);
        bp1     = {1'b0, s_key_byte} + 9'd1;
        sq      = bp1 * bp1;
        term    = sq[HASH_W-1:0] + HASH_W'(pos_reg);
        hash_c  = take ? (hash_reg ^ term) : hash_reg;
        key_c   = key_reg;
        if (take) begin
            key_c = key_reg | (KEY_W'(s_key_byte) << {pos_reg[2:0], 3'b000});
        end
        pos_c   = pos_reg + LEN_W'(take);
        // terminator term (0+1)^2 + length
        final_hash = hash_c ^ (HASH_W'(pos_c) + HASH_W'(1));

        job.cmd      = s_cmd;
        job.too_long = ovf_c;
        job.bucket   = final_hash[BUCKET_W-1:0];
        job.key      = key_c;
        job.len      = pos_c;
        job.value    = s_value;

        hash_next = hash_reg;
        pos_next  = pos_reg;
        key_next  = key_reg;
        ovf_next  = ovf_reg;
        if (accept) begin
            if (s_key_last) begin
                hash_next = '0;
                pos_next  = '0;
                key_next  = '0;
                ovf_next  = 1'b0;
            end else begin
                hash_next = hash_c;
                pos_next  = pos_c;
                key_next  = key_c;
                ovf_next  = ovf_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
            pos_reg  <= '0;
            key_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            hash_reg <= hash_next;
            pos_reg  <= pos_next;
            key_reg  <= key_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

FILE: rtl/shkh_queue.sv
// two entry job queue between front and back end
// depends on shkh_pkg
module shkh_queue import shkh_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    job_t       entry_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = entry_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: rtl/shkh_back.sv
// back end: probes the bucket, updates the slot store, holds the result register
// depends on shkh_pkg, shkh_ram
module shkh_back import shkh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         job_valid,
    output logic         job_ready,
    input  job_t         job,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_status,
    output logic [31:0]  m_value_out
);

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    status_t               res_status_reg, res_status_next;
    logic [VALUE_W-1:0]    res_value_reg, res_value_next;
    logic [BUCKETS-1:0]    row_valid_reg, row_valid_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [VALUE_W-1:0]    m_value_reg, m_value_next;

    // fill count per bucket: slots of a bucket are occupied as a prefix
    logic                  cnt_we;
    logic [BUCKET_W-1:0]   cnt_raddr;
    logic [CNT_W-1:0]      cnt_wdata, cnt_rdata, cnt_cur;
    logic                  slot_we;
    logic [$clog2(TABLE_SLOTS)-1:0] slot_waddr, slot_raddr;
    slot_t                 slot_wdata, slot_rdata;
    logic                  hit, out_free;

    shkh_ram #(.WIDTH(CNT_W), .DEPTH(BUCKETS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (job_reg.bucket),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    shkh_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_value_out = m_value_reg;
    assign job_ready   = state_reg == BS_IDLE;
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        job_next        = job_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        row_valid_next  = row_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;

        cnt_raddr  = job.bucket;
        cnt_we     = 1'b0;
        cnt_wdata  = cnt_reg + CNT_W'(1);
        cnt_cur    = row_valid_reg[job_reg.bucket] ? cnt_rdata : '0;
        slot_raddr = {job_reg.bucket, idx_reg};
        slot_we    = 1'b0;
        slot_waddr = {job_reg.bucket, idx_reg};
        slot_wdata = '{len: job_reg.len, key: job_reg.key, value: job_reg.value};
        hit        = (slot_rdata.key == job_reg.key) && (slot_rdata.len == job_reg.len);

        case (state_reg)
            BS_IDLE: begin
                if (job_valid) begin
                    job_next       = job;
                    idx_next       = '0;
                    res_value_next = '0;
                    if (job.too_long) begin
                        res_status_next = ST_KEY_TOO_LONG;
                        state_next      = BS_DONE;
                    end else begin
                        state_next = BS_CNT;
                    end
                end
            end
            BS_CNT: begin
                cnt_next   = cnt_cur;
                state_next = (cnt_cur == '0) ? BS_MISS : BS_PROBE;
            end
            BS_PROBE: begin
                // read of the next slot overlaps the compare of this one
                slot_raddr = {job_reg.bucket, idx_reg + SLOT_IDX_W'(1)};
                if (hit) begin
                    res_status_next = ST_OK;
                    if (job_reg.cmd == CMD_GET) begin
                        res_value_next = slot_rdata.value;
                    end else begin
                        slot_we = 1'b1;
                    end
                    state_next = BS_DONE;
                end else if (CNT_W'(idx_reg) + CNT_W'(1) == cnt_reg) begin
                    state_next = BS_MISS;
                end else begin
                    idx_next = idx_reg + SLOT_IDX_W'(1);
                end
            end
            BS_MISS: begin
                slot_waddr = {job_reg.bucket, cnt_reg[SLOT_IDX_W-1:0]};
                if (job_reg.cmd == CMD_GET) begin
                    res_status_next = ST_NOT_FOUND;
                end else if (cnt_reg == CNT_W'(SLOTS_PER_BKT)) begin
                    res_status_next = ST_TABLE_FULL;
                end else begin
                    res_status_next = ST_OK;
                    slot_we         = 1'b1;
                    cnt_we          = 1'b1;
                    row_valid_next[job_reg.bucket] = 1'b1;
                end
                state_next = BS_DONE;
            end
            BS_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    state_next    = BS_IDLE;
                end
            end
            default: begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg        <= job_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BS_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BS_PROBE |-> cnt_reg <= CNT_W'(SLOTS_PER_BKT))
        else $error("fill count beyond bucket size");
    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_we |-> (state_reg == BS_PROBE || state_reg == BS_MISS))
        else $error("slot write outside probe");
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> m_value_reg == '0)
        else $error("value returned with error status");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BS_DONE && !out_free) |=> state_reg == BS_DONE)
        else $error("result dropped while output stalled");
`endif

endmodule

FILE: rtl/string_key_hash_table.sv
// top level of the string key hash table
// depends on shkh_pkg, shkh_front, shkh_queue, shkh_back
//
//  channel  dir  handshake           payload
//  s_       in   s_valid / s_ready   s_cmd, s_key_byte, s_key_last, s_value
//  m_       out  m_valid / m_ready   m_status, m_value_out
//
// key bytes are taken one a cycle while the job queue has room; the last byte
// queues a job for the back end; its probe loop reads one slot a cycle, up to n
// slots, n the fill of the bucket (up to 16); a hit ends early, a long key skips it
// reset clears per-bucket valid flags at once, no clearing pass
// front and back stall independently through a two job queue
module string_key_hash_table import shkh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_cmd,
    input  logic [7:0]   s_key_byte,
    input  logic         s_key_last,
    input  logic [31:0]  s_value,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_status,
    output logic [31:0]  m_value_out
);

    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    shkh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_key_byte (s_key_byte),
        .s_key_last (s_key_last),
        .s_value    (s_value),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job        (f_job)
    );

    shkh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_job   (b_job)
    );

    shkh_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (b_valid),
        .job_ready   (b_ready),
        .job         (b_job),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_value_out (m_value_out)
    );

endmodule
